// File: hdl/sfr_pkg.sv
// Shared constants and types for the SLIP frame receiver.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps

package sfr_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned KIND_W = 2;
   localparam int unsigned LEN_W  = 16;

   localparam logic [BYTE_W-1:0] END_CODE     = 8'hC0;
   localparam logic [BYTE_W-1:0] ESC_CODE     = 8'hDB;
   localparam logic [BYTE_W-1:0] ESC_END_CODE = 8'hDC;
   localparam logic [BYTE_W-1:0] ESC_ESC_CODE = 8'hDD;

   localparam logic [KIND_W-1:0] KIND_DATA        = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END_GOOD    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END_DROPPED = 2'd2;

   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd256;
   localparam logic [LEN_W-1:0] COUNT_MAX     = {LEN_W{1'b1}};

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [KIND_W-1:0] kind;
   } rsp_beat_type;

endpackage

// File: hdl/sfr_req_if.sv
// Input channel of the SLIP frame receiver: one raw serial byte per beat.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

interface sfr_req_if import sfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hdl/sfr_rsp_if.sv
// Result channel of the SLIP frame receiver: decoded byte or end marker per beat.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

interface sfr_rsp_if import sfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic [KIND_W-1:0] kind;

   modport source (output valid, output out_byte, output kind, input ready);
   modport sink   (input valid, input out_byte, input kind, output ready);
endinterface

// File: hdl/sfr_csr_if.sv
// Configuration write channel of the SLIP frame receiver (max_len register).
// Depends on sfr_pkg.
`timescale 1ns / 1ps

interface sfr_csr_if import sfr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] max_len;

   modport source (output valid, output max_len, input ready);
   modport sink   (input valid, input max_len, output ready);
endinterface

// File: hdl/slip_frame_receiver_top.sv
// SLIP frame receiver: strips escapes, marks packet ends, drops oversize packets.
// Depends on sfr_pkg, sfr_req_if, sfr_rsp_if and sfr_csr_if.
`timescale 1ns / 1ps

// Usage
//   req_chan: one raw byte off the serial line per beat.
//   rsp_chan: zero or one result per input beat, in order. kind KIND_DATA carries a
//     decoded byte; KIND_END_GOOD / KIND_END_DROPPED close a packet. Empty packets
//     (END END) and escape introducers give no beat; once a packet's raw length
//     passes max_len its remaining bytes give none and its END reports dropped.
//   csr_chan: writes max_len; always ready. Write it only while the block is idle.
// Throughput
//   One input beat per cycle while req_chan.ready is high. Results are registered
//   (in the skid slot while the output register holds an unread result). The
//   escape / count state is updated in the accept cycle, so the next byte can follow at once.
// Stall behavior
//   Results land in an output register backed by a one-entry skid register, so an
//   input beat is still taken while a result waits. req_chan.ready drops only when
//   both are full, and rises again the cycle after the receiver takes a beat.
// Reset
//   Synchronous, active high: clears escape state, raw count, overflow flag, both
//   output slots, and loads max_len with 256.

module slip_frame_receiver_top import sfr_pkg::*; (
   input logic        clock,
   input logic        reset,
   sfr_req_if.sink    req_chan,
   sfr_rsp_if.source  rsp_chan,
   sfr_csr_if.sink    csr_chan
);

   // decoder state
   logic [LEN_W-1:0] max_len_ff;
   logic             esc_pend_ff, esc_pend_in;
   logic [LEN_W-1:0] raw_count_ff, raw_count_in;
   logic             ovf_ff, ovf_in;

   // output register and skid slot
   rsp_beat_type main_ff, skid_ff;
   logic         main_vld_ff, skid_vld_ff;

   logic         accept;
   logic         pop;
   logic         res_vld;
   rsp_beat_type res;
   logic [LEN_W:0] count_next;

   assign req_chan.ready = !skid_vld_ff;
   assign csr_chan.ready = 1'b1;
   assign accept         = req_chan.valid && req_chan.ready;
   assign pop            = main_vld_ff && rsp_chan.ready;

   assign rsp_chan.valid    = main_vld_ff;
   assign rsp_chan.out_byte = main_ff.out_byte;
   assign rsp_chan.kind     = main_ff.kind;

   assign count_next = {1'b0, raw_count_ff} + {{LEN_W{1'b0}}, 1'b1};

   // Decode one byte against the current state.
   always_comb begin
      esc_pend_in  = esc_pend_ff;
      raw_count_in = raw_count_ff;
      ovf_in       = ovf_ff;
      res_vld      = 1'b0;
      res.out_byte = '0;
      res.kind     = KIND_DATA;
      if (req_chan.rx_byte == END_CODE) begin
         // close the packet; an empty one gives nothing, a dangling escape is lost
         res_vld      = (raw_count_ff != '0);
         res.kind     = ovf_ff ? KIND_END_DROPPED : KIND_END_GOOD;
         esc_pend_in  = 1'b0;
         raw_count_in = '0;
         ovf_in       = 1'b0;
      end else begin
         raw_count_in = count_next[LEN_W] ? COUNT_MAX : count_next[LEN_W-1:0];
         ovf_in       = ovf_ff || (count_next > {1'b0, max_len_ff});
         if (!ovf_in) begin
            if (esc_pend_ff) begin
               // any partner other than ESC_END yields ESC and is itself dropped
               esc_pend_in  = 1'b0;
               res_vld      = 1'b1;
               res.out_byte = (req_chan.rx_byte == ESC_END_CODE) ? END_CODE : ESC_CODE;
            end else if (req_chan.rx_byte == ESC_CODE) begin
               esc_pend_in = 1'b1;
            end else begin
               res_vld      = 1'b1;
               res.out_byte = req_chan.rx_byte;
            end
         end
      end
   end

   // Advance decoder state on each accepted beat; take register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MAX_LEN_RESET;
         esc_pend_ff  <= 1'b0;
         raw_count_ff <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            max_len_ff <= csr_chan.max_len;
         end
         if (accept) begin
            esc_pend_ff  <= esc_pend_in;
            raw_count_ff <= raw_count_in;
            ovf_ff       <= ovf_in;
         end
      end
   end

   // Output register with skid: refill main from skid on a pop, else park new
   // results in main when free, else in skid.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (pop) begin
         if (skid_vld_ff) begin
            main_ff     <= skid_ff;
            skid_vld_ff <= 1'b0;
         end else if (accept && res_vld) begin
            main_ff <= res;
         end else begin
            main_vld_ff <= 1'b0;
         end
      end else if (accept && res_vld) begin
         if (!main_vld_ff) begin
            main_ff     <= res;
            main_vld_ff <= 1'b1;
         end else begin
            skid_ff     <= res;
            skid_vld_ff <= 1'b1;
         end
      end
   end

endmodule
